### rtl/core/svr_pkg.sv
// Shared types, constants and sine table builder for the swept-rate vibrato oscillator.
// Used by svr_cfg_regs, svr_sine_rom and swept_rate_vibrato_oscillator_core.
`default_nettype none

package svr_pkg;

    // Table and phase geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int TBL_N           = 1 << SINE_TABLE_BITS;
    localparam int MAG_W           = 15;

    // Register and state widths
    localparam int STEP_W     = 32;
    localparam int RATE_W     = 48;
    localparam int RATE_FRAC  = 16;
    localparam int AMP_W      = 15;
    localparam int HALF_W     = 24;
    localparam int COUNT_W    = HALF_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_RATE_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_RATE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LENGTH    = 3'd5;

    // Register values after reset
    localparam logic [STEP_W-1:0] RST_CARRIER_STEP   = 32'd53989979;
    localparam logic [STEP_W-1:0] RST_DEVIATION_STEP = 32'd973915;
    localparam logic [RATE_W-1:0] RST_LFO_RATE_MIN   = 48'd638265249;
    localparam logic [RATE_W-1:0] RST_LFO_RATE_STEP  = 48'd83944;
    localparam logic [AMP_W-1:0]  RST_AMPLITUDE      = 15'd3000;
    localparam logic [HALF_W-1:0] RST_HALF_LENGTH    = 24'd220500;

    localparam logic [MAG_W-1:0] SINE_MAX = {MAG_W{1'b1}};

    typedef struct packed {
        logic [STEP_W-1:0] carrier_step;
        logic [STEP_W-1:0] deviation_step;
        logic [RATE_W-1:0] lfo_rate_min;
        logic [RATE_W-1:0] lfo_rate_step;
        logic [AMP_W-1:0]  amplitude;
        logic [HALF_W-1:0] half_length;
    } cfg_t;

    typedef logic [MAG_W-1:0] sine_rom_t [TBL_N];

    // Q30 constants for the Taylor series used to fill the table
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] SINE_DIVS [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // One quarter-wave entry: degree-13 polynomial in Q30, rounded to Q0.15
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        x  = (Q30_HALF_PI * 64'(i)) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 6; k++)
        begin
            t = Q30_ONE - (((x2 * t) >> 30) / SINE_DIVS[k]);
        end
        s = (x * t) >> 30;
        e = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (e > 64'd32767)
        begin
            e = 64'd32767;
        end
        return MAG_W'(e);
    endfunction

    // Whole table, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int unsigned i = 0; i < TBL_N; i++)
        begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    // Table address for a phase; odd quadrants read mirrored
    function automatic logic [SINE_TABLE_BITS-1:0] sine_addr(input logic [PHASE_BITS-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] idx;
        idx = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
        return ph[PHASE_BITS-2] ? (SINE_TABLE_BITS'(0) - idx) : idx;
    endfunction

endpackage

`default_nettype wire

### rtl/core/swept_rate_vibrato_oscillator_core.sv
// DDS sine oscillator with a swept-rate sine LFO for vibrato. One item in, one result out.
// Result valid the cycle after the item is accepted; one item per cycle while not stalled.
// The sine ROM is addressed from next-state phases, so its registered data always matches
// the current phase registers.
// Reset: phases, count, LFO rate and finished flag clear; registers take their defaults.
// Depends on svr_pkg, svr_cfg_regs and svr_sine_rom.
`default_nettype none

module swept_rate_vibrato_oscillator_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item input
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           restart,
    // result output
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [15:0]                  sample,
    output logic                                last,
    output logic                                done_res,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [svr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [svr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PB = svr_pkg::PHASE_BITS;
    localparam int TB = svr_pkg::SINE_TABLE_BITS;
    localparam int MW = svr_pkg::MAG_W;
    localparam int RW = svr_pkg::RATE_W;
    localparam int CW = svr_pkg::COUNT_W;
    localparam int SW = svr_pkg::STEP_W;
    localparam int AW = svr_pkg::AMP_W;
    localparam logic [MW-1:0] SINE_ZERO = svr_pkg::sine_entry(0);

    svr_pkg::cfg_t cfg;

    logic [PB-1:0] carrier_phase_reg, carrier_phase_next;
    logic [PB-1:0] lfo_phase_reg,     lfo_phase_next;
    logic [RW-1:0] lfo_rate_reg,      lfo_rate_next;
    logic [CW-1:0] count_reg,         count_next;
    logic          finished_reg,      finished_next;

    logic              out_valid_reg;
    logic signed [15:0] sample_reg;
    logic              last_reg;
    logic              done_reg;

    logic [MW-1:0] rom_c, rom_l;
    logic          accept;

    // per-item working values
    logic [PB-1:0]     c_ph, l_ph;
    logic [RW-1:0]     rate_eff;
    logic [CW-1:0]     count_eff;
    logic              fin_eff;
    logic [MW-1:0]     c_mag, l_mag;
    logic [AW+MW-1:0]  amp_prod;
    logic [MW-1:0]     smp_mag;
    logic signed [15:0] smp_val;
    logic [SW+MW-1:0]  dev_prod;
    logic [SW-1:0]     dev;
    logic [SW-1:0]     step;
    logic [RW:0]       rate_sum;
    logic [RW-1:0]     rate_up, rate_dn;
    logic [svr_pkg::HALF_W-1:0] half;
    logic [CW-1:0]     total;
    logic [CW:0]       count_inc;
    logic              is_last;

    svr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    svr_sine_rom u_rom
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .addr_a (svr_pkg::sine_addr(carrier_phase_next)),
        .addr_b (svr_pkg::sine_addr(lfo_phase_next)),
        .data_a (rom_c),
        .data_b (rom_l)
    );

    // Handshake: take an item whenever the output register is free or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Restart overrides state for this tick
    assign c_ph      = restart ? '0 : carrier_phase_reg;
    assign l_ph      = restart ? '0 : lfo_phase_reg;
    assign rate_eff  = restart ? cfg.lfo_rate_min : lfo_rate_reg;
    assign count_eff = restart ? '0 : count_reg;
    assign fin_eff   = restart ? 1'b0 : finished_reg;

    // Sine magnitudes; mirrored index zero in odd quadrants is full scale
    always_comb
    begin
        if (restart)
            c_mag = SINE_ZERO;
        else if (c_ph[PB-2] && (c_ph[PB-3 -: TB] == '0))
            c_mag = svr_pkg::SINE_MAX;
        else
            c_mag = rom_c;
        if (restart)
            l_mag = SINE_ZERO;
        else if (l_ph[PB-2] && (l_ph[PB-3 -: TB] == '0))
            l_mag = svr_pkg::SINE_MAX;
        else
            l_mag = rom_l;
    end

    // Output sample; magnitude stays below 2^15 so the signed range is never exceeded
    assign amp_prod = cfg.amplitude * c_mag;
    assign smp_mag  = amp_prod[AW+MW-1 -: MW];
    assign smp_val  = c_ph[PB-1] ? -$signed({1'b0, smp_mag}) : $signed({1'b0, smp_mag});

    // Carrier increment with vibrato deviation
    assign dev_prod = cfg.deviation_step * l_mag;
    assign dev      = dev_prod[SW+MW-1 -: SW];
    assign step     = l_ph[PB-1] ? (cfg.carrier_step - dev) : (cfg.carrier_step + dev);

    // LFO rate sweep with saturation at both ends
    assign rate_sum = {1'b0, rate_eff} + {1'b0, cfg.lfo_rate_step};
    assign rate_up  = rate_sum[RW] ? {RW{1'b1}} : rate_sum[RW-1:0];
    assign rate_dn  = (rate_eff < cfg.lfo_rate_step) ? '0 : (rate_eff - cfg.lfo_rate_step);

    // Note length; zero half length counts as one
    assign half      = (cfg.half_length == '0) ? svr_pkg::HALF_W'(1) : cfg.half_length;
    assign total     = {half, 1'b0};
    assign count_inc = {1'b0, count_eff} + (CW+1)'(1);
    assign is_last   = count_inc >= {1'b0, total};

    // Next state: only an accepted, non-silent item moves the oscillator
    always_comb
    begin
        carrier_phase_next = carrier_phase_reg;
        lfo_phase_next     = lfo_phase_reg;
        lfo_rate_next      = lfo_rate_reg;
        count_next         = count_reg;
        finished_next      = finished_reg;
        if (accept && !fin_eff)
        begin
            carrier_phase_next = c_ph + PB'(step);
            lfo_phase_next     = l_ph + PB'(rate_eff >> svr_pkg::RATE_FRAC);
            lfo_rate_next      = (count_eff < CW'(half)) ? rate_up : rate_dn;
            count_next         = is_last ? count_eff : count_inc[CW-1:0];
            finished_next      = is_last;
        end
    end

    // Oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg <= '0;
            lfo_phase_reg     <= '0;
            lfo_rate_reg      <= '0;
            count_reg         <= '0;
            finished_reg      <= 1'b0;
        end
        else
        begin
            carrier_phase_reg <= carrier_phase_next;
            lfo_phase_reg     <= lfo_phase_next;
            lfo_rate_reg      <= lfo_rate_next;
            count_reg         <= count_next;
            finished_reg      <= finished_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= fin_eff ? 16'sd0 : smp_val;
            last_reg   <= !fin_eff && is_last;
            done_reg   <= fin_eff;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;
    assign done_res  = done_reg;

    // Checks
    a_last_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(last && done_res))
        else $error("last and done_res both set");

    a_silent_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (sample == 16'sd0))
        else $error("silent item carries a non-zero sample");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !fin_eff && is_last) |=> finished_reg)
        else $error("note end not recorded");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(carrier_phase_reg) && $stable(lfo_rate_reg)))
        else $error("oscillator state moved without an item");

endmodule

`default_nettype wire

### rtl/core/svr_cfg_regs.sv
// Configuration register bank for the swept-rate vibrato oscillator.
// Depends on svr_pkg for widths, indexes and reset values.
`default_nettype none

module svr_cfg_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [svr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [svr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output svr_pkg::cfg_t                         cfg
);

    svr_pkg::cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_step   <= svr_pkg::RST_CARRIER_STEP;
            cfg_reg.deviation_step <= svr_pkg::RST_DEVIATION_STEP;
            cfg_reg.lfo_rate_min   <= svr_pkg::RST_LFO_RATE_MIN;
            cfg_reg.lfo_rate_step  <= svr_pkg::RST_LFO_RATE_STEP;
            cfg_reg.amplitude      <= svr_pkg::RST_AMPLITUDE;
            cfg_reg.half_length    <= svr_pkg::RST_HALF_LENGTH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                svr_pkg::CFG_CARRIER_STEP:
                    cfg_reg.carrier_step   <= cfg_wdata[svr_pkg::STEP_W-1:0];
                svr_pkg::CFG_DEVIATION_STEP:
                    cfg_reg.deviation_step <= cfg_wdata[svr_pkg::STEP_W-1:0];
                svr_pkg::CFG_LFO_RATE_MIN:
                    cfg_reg.lfo_rate_min   <= cfg_wdata[svr_pkg::RATE_W-1:0];
                svr_pkg::CFG_LFO_RATE_STEP:
                    cfg_reg.lfo_rate_step  <= cfg_wdata[svr_pkg::RATE_W-1:0];
                svr_pkg::CFG_AMPLITUDE:
                    cfg_reg.amplitude      <= cfg_wdata[svr_pkg::AMP_W-1:0];
                svr_pkg::CFG_HALF_LENGTH:
                    cfg_reg.half_length    <= cfg_wdata[svr_pkg::HALF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/svr_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Contents come from svr_pkg::build_sine_rom at elaboration.
`default_nettype none

module svr_sine_rom
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [svr_pkg::SINE_TABLE_BITS-1:0] addr_a,
    input  wire logic [svr_pkg::SINE_TABLE_BITS-1:0] addr_b,
    output logic      [svr_pkg::MAG_W-1:0]           data_a,
    output logic      [svr_pkg::MAG_W-1:0]           data_b
);

    localparam svr_pkg::sine_rom_t SINE_ROM = svr_pkg::build_sine_rom();

    logic [svr_pkg::MAG_W-1:0] data_a_reg;
    logic [svr_pkg::MAG_W-1:0] data_b_reg;

    // Reset value matches the entry for the reset address (zero phase)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_a_reg <= SINE_ROM[0];
            data_b_reg <= SINE_ROM[0];
        end
        else
        begin
            data_a_reg <= SINE_ROM[addr_a];
            data_b_reg <= SINE_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire
